/* design/dot_noise_window_eraser_top_macros.svh */
// assertion macros for the dot noise window eraser checker
// all macros expect a clock named clk and a reset named rst in scope
`ifndef DOT_NOISE_WINDOW_ERASER_TOP_MACROS_SVH
`define DOT_NOISE_WINDOW_ERASER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define DNWE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DNWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after reset
`define DNWE_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

/* design/dnwe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnwe_pkg
// shared types and constants of the dot noise window eraser
// ----------------------------------------------------------------------------
package dnwe_pkg;

  localparam int PIX_W      = 24;
  localparam int RING_N     = 8;
  localparam int POS_W      = $clog2(RING_N);
  localparam int CNT_W      = $clog2(RING_N + 1);
  localparam int KEEP_COUNT = 3;

  localparam logic [PIX_W-1:0] PIX_WHITE = 24'hff_ffff;
  localparam logic [PIX_W-1:0] PIX_BLACK = 24'h00_0000;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [RING_N-1:0] ring_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // what one lane learns about its ring position
  typedef struct packed {
    logic eq;     // neighbor equals center
    logic first;  // first occurrence of this color on the ring
    logic mono;   // neighbor is pure white or black
    cnt_t cnt;    // occurrences of this color from here to the ring end
    pix_t color;
  } lane_res_t;

  typedef lane_res_t [RING_N-1:0] lane_vec_t;

  function automatic logic is_mono(input pix_t c);
    return (c == PIX_WHITE) || (c == PIX_BLACK);
  endfunction

endpackage

/* design/dnwe_win_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnwe_win_if
// input channel: one 3x3 window of packed rgb pixels per transfer
// ----------------------------------------------------------------------------
interface dnwe_win_if;
  logic          valid;
  logic          ready;
  dnwe_pkg::pix_t top_left;
  dnwe_pkg::pix_t top_mid;
  dnwe_pkg::pix_t top_right;
  dnwe_pkg::pix_t mid_left;
  dnwe_pkg::pix_t center;
  dnwe_pkg::pix_t mid_right;
  dnwe_pkg::pix_t bottom_left;
  dnwe_pkg::pix_t bottom_mid;
  dnwe_pkg::pix_t bottom_right;

  modport source (
    output valid, top_left, top_mid, top_right, mid_left, center, mid_right,
           bottom_left, bottom_mid, bottom_right,
    input  ready
  );

  modport sink (
    input  valid, top_left, top_mid, top_right, mid_left, center, mid_right,
           bottom_left, bottom_mid, bottom_right,
    output ready
  );
endinterface

/* design/dnwe_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnwe_res_if
// output channel: replace decision, replacement color and its ring position
// ----------------------------------------------------------------------------
interface dnwe_res_if;
  logic           valid;
  logic           ready;
  logic           replace;
  dnwe_pkg::pix_t new_color;
  dnwe_pkg::pos_t source_pos;

  modport source (
    output valid, replace, new_color, source_pos,
    input  ready
  );

  modport sink (
    input  valid, replace, new_color, source_pos,
    output ready
  );
endinterface

/* design/dot_noise_window_eraser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dot_noise_window_eraser_top
// isolated dot detection and replacement on a 3x3 rgb window
// ----------------------------------------------------------------------------
// usage
//   win: one 3x3 window of packed rgb pixels per transfer (valid/ready)
//   res: one result per window, in order: replace flag, replacement color
//        (zero when kept) and ring position of the chosen neighbor
//   pipeline: lane registers, then the merge output register, drive res
//   throughput: one window per clock unless res is held off; eight lanes,
//        one per ring position, compare their neighbor against the center
//        and all other neighbors in parallel, so no stage iterates
//   stall: when res is held off the two stages fill up, after which win
//        ready drops; no result is lost or repeated
//   reset: rst is synchronous, active high, and empties both stages; no
//        configuration and no stored state beyond the pipeline
// ----------------------------------------------------------------------------
module dot_noise_window_eraser_top (
  input  logic              clk,
  input  logic              rst,
  dnwe_win_if.sink          win,
  dnwe_res_if.source        res
);

  localparam int N = dnwe_pkg::RING_N;

  dnwe_pkg::ring_t     ring;
  dnwe_pkg::lane_vec_t lanes;

  logic s1_valid;     // lane stage holds a window
  logic s1_adv;       // lane stage loads this cycle
  logic out_adv;      // output stage loads this cycle

  // ring order: clockwise from the top left
  assign ring[0] = win.top_left;
  assign ring[1] = win.top_mid;
  assign ring[2] = win.top_right;
  assign ring[3] = win.mid_right;
  assign ring[4] = win.bottom_right;
  assign ring[5] = win.bottom_mid;
  assign ring[6] = win.bottom_left;
  assign ring[7] = win.mid_left;

  // each stage moves when it is empty or its successor moves
  assign out_adv   = !res.valid || res.ready;
  assign s1_adv    = !s1_valid || out_adv;
  assign win.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= win.valid;
      end
      if (out_adv) begin
        res.valid <= s1_valid;
      end
    end
  end

  // one lane per ring position
  for (genvar g = 0; g < N; g++) begin : g_lane
    dnwe_lane #(
      .LANE_IDX (g)
    ) u_lane (
      .clk    (clk),
      .en     (s1_adv),
      .ring   (ring),
      .center (win.center),
      .res    (lanes[g])
    );
  end

  // decision and output register
  dnwe_merge u_merge (
    .clk        (clk),
    .en         (out_adv),
    .lanes      (lanes),
    .replace    (res.replace),
    .new_color  (res.new_color),
    .source_pos (res.source_pos)
  );

endmodule

/* design/dnwe_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnwe_lane
// per ring position: center match, first occurrence and color count
// ----------------------------------------------------------------------------
module dnwe_lane #(
  parameter int LANE_IDX = 0
) (
  input  logic                clk,
  input  logic                en,
  input  dnwe_pkg::ring_t     ring,
  input  dnwe_pkg::pix_t      center,
  output dnwe_pkg::lane_res_t res
);

  dnwe_pkg::lane_res_t res_next;

  always_comb begin
    res_next.color = ring[LANE_IDX];
    res_next.eq    = (ring[LANE_IDX] == center);
    res_next.mono  = dnwe_pkg::is_mono(ring[LANE_IDX]);
    res_next.first = 1'b1;
    res_next.cnt   = '0;
    for (int j = 0; j < dnwe_pkg::RING_N; j++) begin
      if (ring[j] == ring[LANE_IDX]) begin
        if (j < LANE_IDX) begin
          res_next.first = 1'b0;
        end else begin
          res_next.cnt = res_next.cnt + dnwe_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

/* design/dnwe_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnwe_merge
// combines the lane findings into the keep or replace decision
// ----------------------------------------------------------------------------
module dnwe_merge (
  input  logic                clk,
  input  logic                en,
  input  dnwe_pkg::lane_vec_t lanes,
  output logic                replace,
  output dnwe_pkg::pix_t      new_color,
  output dnwe_pkg::pos_t      source_pos
);

  localparam int N = dnwe_pkg::RING_N;

  logic [N-1:0]   eq_v;
  logic [N-1:0]   first_v;
  logic [N-1:0]   mono_v;
  logic [N-1:0]   eq_rot;
  dnwe_pkg::cnt_t n_eq;
  dnwe_pkg::cnt_t best_cnt;
  dnwe_pkg::pos_t best_pos;
  logic           found;
  logic           keep;
  logic           replace_next;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      eq_v[i]    = lanes[i].eq;
      first_v[i] = lanes[i].first;
      mono_v[i]  = lanes[i].mono;
    end
    // eq_rot[i] is the match flag of the clockwise neighbor, wrapping
    eq_rot = {eq_v[0], eq_v[N-1:1]};
    n_eq   = dnwe_pkg::CNT_W'($countones(eq_v));

    // a matching neighbor carries the center color, so it tells whether the
    // center is white or black
    keep = (n_eq >= dnwe_pkg::CNT_W'(dnwe_pkg::KEEP_COUNT))
        || (|(eq_v & eq_rot))
        || ((n_eq != '0) && (|(eq_v & mono_v)) && (&(~first_v | mono_v)));

    // most frequent other color, earliest first occurrence wins a tie
    best_cnt = '0;
    best_pos = '0;
    found    = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (!eq_v[i] && first_v[i] && (lanes[i].cnt > best_cnt)) begin
        best_cnt = lanes[i].cnt;
        best_pos = dnwe_pkg::POS_W'(i);
        found    = 1'b1;
      end
    end
    replace_next = !keep && found;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      replace    <= replace_next;
      new_color  <= replace_next ? lanes[best_pos].color : '0;
      source_pos <= replace_next ? best_pos : '0;
    end
  end

endmodule

/* design/dnwe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnwe_checker
// port level checks of the dot noise window eraser
// ----------------------------------------------------------------------------
`include "dot_noise_window_eraser_top_macros.svh"

module dnwe_checker (
  input logic           clk,
  input logic           rst,
  input logic           win_valid,
  input logic           win_ready,
  input logic           res_valid,
  input logic           res_ready,
  input logic           res_replace,
  input dnwe_pkg::pix_t res_new_color,
  input dnwe_pkg::pos_t res_source_pos
);

  `DNWE_ASSERT_RST(a_rst_empty, !res_valid, "result valid right after reset")

  `DNWE_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
    res_valid && $stable(res_replace) && $stable(res_new_color)
      && $stable(res_source_pos), "stalled result changed")

  `DNWE_ASSERT_NOW(a_keep_zero, res_valid && !res_replace,
    (res_new_color == '0) && (res_source_pos == '0), "kept window carries payload")

  `DNWE_ASSERT_NOW(a_ready_only_on_stall, !win_ready,
    res_valid && !res_ready, "input held off without an output stall")

endmodule

bind dot_noise_window_eraser_top dnwe_checker u_dnwe_checker (
  .clk            (clk),
  .rst            (rst),
  .win_valid      (win.valid),
  .win_ready      (win.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_replace    (res.replace),
  .res_new_color  (res.new_color),
  .res_source_pos (res.source_pos)
);
